>>> hdl/acmd_pkg.sv
// Shared types, widths and register codes for the alpha coverage mip downsampler.
`timescale 1ns / 1ps
package acmd_pkg;

	// Channel and arithmetic widths
	localparam int CHAN_W = 8;                  // one color or alpha code
	localparam int PIX_W = 4 * CHAN_W;          // packed RGBA8 pixel
	localparam int PROD_W = 2 * CHAN_W;         // color times alpha
	localparam int NUM_W = PROD_W + 2;          // sum of four products
	localparam int ASUM_W = CHAN_W + 2;         // sum of four alphas
	localparam int NPASS_W = 3;                 // 0..4 passing pixels
	localparam int MIX_W = 13;                  // boosted alpha before the divide by 16
	localparam int DEN_W = NUM_W;               // shifted divisor

	// Divider layout: quotient bits retired per stage, stage count
	localparam int DIV_STAGES = 4;
	localparam int BITS_PER_DIV_STAGE = CHAN_W / DIV_STAGES;
	localparam int PIPE_STAGES = 2 + DIV_STAGES;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_ALPHA_THRESHOLD = 1'b0;
	localparam logic REG_BOOST_TARGET = 1'b1;
	localparam logic [CHAN_W-1:0] ALPHA_THRESHOLD_RST = 8'd128;
	localparam logic [CHAN_W-1:0] BOOST_TARGET_RST = 8'd153;

	// Input item: one 2x2 block
	typedef struct packed {
		logic [PIX_W-1:0] pixel_top_left;
		logic [PIX_W-1:0] pixel_top_right;
		logic [PIX_W-1:0] pixel_bottom_left;
		logic [PIX_W-1:0] pixel_bottom_right;
	} src_item_t;

	// Result item: one downsampled pixel
	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} res_item_t;

	// Work carried through the divider stages (channels 0 red, 1 green, 2 blue)
	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][CHAN_W-1:0] quot;
		logic [DEN_W-1:0] den;
		logic [CHAN_W-1:0] alpha;
	} div_work_t;

endpackage

>>> hdl/acmd_cfg.sv
// APB-style register file holding the alpha threshold and boost target.
`timescale 1ns / 1ps
module acmd_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acmd_pkg::ADDR_W-1:0] paddr,
	input  logic [acmd_pkg::DATA_W-1:0] pwdata,
	output logic [acmd_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [acmd_pkg::CHAN_W-1:0] alpha_threshold,
	output logic [acmd_pkg::CHAN_W-1:0] boost_target
);
	import acmd_pkg::*;

	logic [CHAN_W-1:0] alpha_threshold_q;
	logic [CHAN_W-1:0] boost_target_q;
	logic wr_en;
	logic reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	// Register writes, upper data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_threshold_q <= ALPHA_THRESHOLD_RST;
			boost_target_q <= BOOST_TARGET_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ALPHA_THRESHOLD: alpha_threshold_q <= pwdata[CHAN_W-1:0];
				REG_BOOST_TARGET: boost_target_q <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_ALPHA_THRESHOLD: prdata = DATA_W'(alpha_threshold_q);
			REG_BOOST_TARGET: prdata = DATA_W'(boost_target_q);
			default: prdata = '0;
		endcase
	end

	assign alpha_threshold = alpha_threshold_q;
	assign boost_target = boost_target_q;

endmodule

>>> hdl/acmd_front.sv
// Front stages: per-pixel products and alpha test, then sums and coverage alpha.
`timescale 1ns / 1ps
module acmd_front (
	input  logic clk,
	input  logic en_s1,
	input  logic en_s2,
	input  acmd_pkg::src_item_t src_item,
	input  logic [acmd_pkg::CHAN_W-1:0] alpha_threshold,
	input  logic [acmd_pkg::CHAN_W-1:0] boost_target,
	output acmd_pkg::div_work_t work
);
	import acmd_pkg::*;

	logic [3:0][PIX_W-1:0] px;
	logic [3:0][2:0][PROD_W-1:0] prod_s1;
	logic [ASUM_W-1:0] asum_s1;
	logic [NPASS_W-1:0] npass_s1;
	logic [ASUM_W-1:0] asum_c;
	logic [NPASS_W-1:0] npass_c;
	logic [2:0][NUM_W-1:0] csum_c;
	logic [MIX_W-1:0] plain_c;
	logic [MIX_W-1:0] boosted_c;
	logic [MIX_W-1:0] best_c;
	logic [MIX_W-5:0] scaled_c;
	logic [CHAN_W-1:0] alpha_c;
	div_work_t work_s2;

	assign px = {src_item.pixel_bottom_right, src_item.pixel_bottom_left,
		src_item.pixel_top_right, src_item.pixel_top_left};

	// Alpha sum and pass count over the four pixels
	always_comb begin
		asum_c = '0;
		npass_c = '0;
		for (int i = 0; i < 4; i++) begin
			asum_c = asum_c + ASUM_W'(px[i][31:24]);
			npass_c = npass_c + NPASS_W'(px[i][31:24] >= alpha_threshold);
		end
	end

	// Stage 1: color times alpha, one 8x8 product per channel and pixel
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 4; i++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[i][c] <= PROD_W'(px[i][c*CHAN_W +: CHAN_W])
						* PROD_W'(px[i][31:24]);
				end
			end
			asum_s1 <= asum_c;
			npass_s1 <= npass_c;
		end
	end

	// Weighted color sums
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			csum_c[c] = NUM_W'(prod_s1[0][c]) + NUM_W'(prod_s1[1][c])
				+ NUM_W'(prod_s1[2][c]) + NUM_W'(prod_s1[3][c]);
		end
	end

	// Coverage alpha: raise toward boost in proportion to passing pixels
	always_comb begin
		plain_c = MIX_W'({asum_s1, 2'b00});
		boosted_c = MIX_W'({npass_s1, 2'b00}) * MIX_W'(boost_target)
			+ MIX_W'(NPASS_W'(3'd4) - npass_s1) * MIX_W'(asum_s1);
		best_c = (boosted_c > plain_c) ? boosted_c : plain_c;
		scaled_c = best_c[MIX_W-1:4];
		if (npass_s1 == '0) begin
			alpha_c = asum_s1[ASUM_W-1:2];
		end else if (scaled_c > (MIX_W-4)'(8'd255)) begin
			alpha_c = 8'd255;
		end else begin
			alpha_c = scaled_c[CHAN_W-1:0];
		end
	end

	// Stage 2: load the divider; a zero alpha sum gets an all-ones divisor
	// so every quotient bit comes out zero
	always_ff @(posedge clk) begin
		if (en_s2) begin
			work_s2.rem <= csum_c;
			work_s2.quot <= '0;
			work_s2.den <= (asum_s1 == '0) ? '1 : DEN_W'({asum_s1, 7'b0});
			work_s2.alpha <= alpha_c;
		end
	end

	assign work = work_s2;

endmodule

>>> hdl/acmd_div_stage.sv
// One restoring-divide stage: retires two quotient bits on all three channels.
`timescale 1ns / 1ps
module acmd_div_stage (
	input  logic clk,
	input  logic en,
	input  acmd_pkg::div_work_t work_in,
	output acmd_pkg::div_work_t work_out
);
	import acmd_pkg::*;

	div_work_t nxt;
	div_work_t work_q;

	// Compare-subtract, then halve the divisor for the next bit
	always_comb begin
		nxt = work_in;
		for (int b = 0; b < BITS_PER_DIV_STAGE; b++) begin
			for (int c = 0; c < 3; c++) begin
				if (nxt.rem[c] >= nxt.den) begin
					nxt.rem[c] = nxt.rem[c] - nxt.den;
					nxt.quot[c] = {nxt.quot[c][CHAN_W-2:0], 1'b1};
				end else begin
					nxt.quot[c] = {nxt.quot[c][CHAN_W-2:0], 1'b0};
				end
			end
			nxt.den = nxt.den >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= nxt;
		end
	end

	assign work_out = work_q;

endmodule

>>> hdl/alpha_coverage_mip_downsample_top.sv
// Top level of the alpha coverage mip downsampler: control, register file, datapath.
`timescale 1ns / 1ps
// Takes one 2x2 RGBA8 block per item and returns one RGBA8 pixel: RGB is the
// alpha-weighted average (zero when all four alphas are zero) and alpha is the
// box average raised toward boost_target by the share of pixels at or above
// alpha_threshold. A new item is taken every cycle unless src_stall is high;
// each result passes two front stages (products, then sums and coverage alpha)
// and four divider stages that each produce two quotient bits. The pipeline
// moves on a per-stage ready chain, so empty stages fill while the result side
// stalls; src_stall rises only with all six stages full. Registers must be
// written through the APB port only while no items are in flight; not enforced.
module alpha_coverage_mip_downsample_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acmd_pkg::ADDR_W-1:0] paddr,
	input  logic [acmd_pkg::DATA_W-1:0] pwdata,
	output logic [acmd_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic src_valid,
	output logic src_stall,
	input  acmd_pkg::src_item_t src_item,
	output logic res_valid,
	input  logic res_stall,
	output acmd_pkg::res_item_t res_item
);
	import acmd_pkg::*;

	logic [CHAN_W-1:0] alpha_threshold;
	logic [CHAN_W-1:0] boost_target;
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] rdy;
	div_work_t work [DIV_STAGES+1];

	acmd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.alpha_threshold(alpha_threshold),
		.boost_target(boost_target)
	);

	// Ready chain: a stage loads when empty or when the next one loads
	always_comb begin
		rdy[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !res_stall;
		for (int k = PIPE_STAGES-2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? src_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign src_stall = !rdy[0];
	assign res_valid = vld_q[PIPE_STAGES-1];

	acmd_front u_front (
		.clk(clk),
		.en_s1(rdy[0]),
		.en_s2(rdy[1]),
		.src_item(src_item),
		.alpha_threshold(alpha_threshold),
		.boost_target(boost_target),
		.work(work[0])
	);

	// Divider stages
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		acmd_div_stage u_div (
			.clk(clk),
			.en(rdy[g+2]),
			.work_in(work[g]),
			.work_out(work[g+1])
		);
	end

	// Result from the last divider stage
	assign res_item.out_red = work[DIV_STAGES].quot[0];
	assign res_item.out_green = work[DIV_STAGES].quot[1];
	assign res_item.out_blue = work[DIV_STAGES].quot[2];
	assign res_item.out_alpha = work[DIV_STAGES].alpha;

	// An accepted item always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> vld_q[0])
		else $error("accepted item missing from stage 1");

	// Input stalls only when every stage is full and the result is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (vld_q == '1) && res_stall)
		else $error("input stalled with room in the pipeline");

	// An item in the next-to-last stage moves to the output when it loads
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PIPE_STAGES-2] && rdy[PIPE_STAGES-1] |=> vld_q[PIPE_STAGES-1])
		else $error("item lost between last two stages");

endmodule

>>> bench/alpha_coverage_mip_downsample_top_tb.sv
// Self-checking bench for the alpha coverage mip downsampler: stimulus, prediction, checking.
`timescale 1ns / 1ps
module alpha_coverage_mip_downsample_top_tb;
	import acmd_pkg::*;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int RANDOM_PHASE = 6;
	localparam int LONG_HOLD = 300;          // receiver hold-off used to fill the pipeline
	localparam int SETTLE_CYCLES = 2 * PIPE_STAGES + 4;
	localparam int DIR_ROWS_N = 12;

	// Directed row: block, whether the result is typed in, and that result
	typedef struct packed {
		src_item_t blk;
		logic typed;
		res_item_t want;
	} stim_row_t;

	// Pixels pack as alpha, blue, green, red; results as red, green, blue, alpha
	localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
		// all zero
		{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		// all ones: full color, full alpha
		{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		// zero alpha sum with full color
		{32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 1'b1, 32'h0000_0000},
		// opaque black everywhere
		{32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 1'b1, 32'h0000_00FF},
		// one opaque pixel, three transparent
		{32'hFF11_2233, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
		// all just below the threshold
		{32'h7F80_C0FF, 32'h7F01_0203, 32'h7FFE_FDFC, 32'h7F55_AA55, 1'b0, 32'h0},
		// all exactly at the threshold: boost lifts the average
		{32'h8012_3456, 32'h80FF_0000, 32'h8000_FF00, 32'h8000_00FF, 1'b0, 32'h0},
		// boost below the plain average
		{32'hC8AB_CDEF, 32'hC810_2030, 32'hC8FF_FFFF, 32'hC800_0000, 1'b0, 32'h0},
		// smallest nonzero alpha sum
		{32'h01FF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
		// mixed alphas around the threshold
		{32'hFF00_00FF, 32'h80FF_00FF, 32'h7F00_FF00, 32'h00FF_FFFF, 1'b0, 32'h0},
		// one channel per pixel, checks channel order
		{32'hFF00_00FF, 32'hFF00_FF00, 32'hFFFF_0000, 32'h00FF_FFFF, 1'b0, 32'h0},
		// uniform low alpha, no pixel passes
		{32'h4012_3456, 32'h4065_4321, 32'h40FF_00FF, 32'h4000_FF00, 1'b0, 32'h0}
	};

	// Register settings, idling, fill and drain per random phase
	localparam logic [7:0] PH_THR [PHASES] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd127, 8'd0,
		8'd128};
	localparam logic [7:0] PH_BOOST [PHASES] = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd254, 8'd128,
		8'd0, 8'd153};
	localparam int PH_SRC_MAX [PHASES] = '{15, 0, 15, 0, 15, 0, 15, 15};
	localparam int PH_RES_MAX [PHASES] = '{15, 0, 0, 15, 15, 0, 15, 15};
	localparam bit PH_FILL [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam bit PH_DRAIN [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic src_valid = 1'b0;
	logic src_stall;
	src_item_t src_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res_item;

	// Bench copy of the registers
	logic [7:0] thr_reg = ALPHA_THRESHOLD_RST;
	logic [7:0] boost_reg = BOOST_TARGET_RST;

	res_item_t pending_pixels [$];
	int mismatch_count = 0;
	int src_idle_max = 15;
	int res_idle_max = 15;
	bit long_hold_req = 1'b0;

	alpha_coverage_mip_downsample_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Alpha-weighted color average plus coverage-preserving alpha
	function automatic res_item_t downsample_block(src_item_t blk);
		logic [31:0] px [4];
		int unsigned a, n, s_r, s_g, s_b, s_a, plain, boosted, oa;
		res_item_t r;
		px[0] = blk.pixel_top_left;
		px[1] = blk.pixel_top_right;
		px[2] = blk.pixel_bottom_left;
		px[3] = blk.pixel_bottom_right;
		n = 0;
		s_r = 0;
		s_g = 0;
		s_b = 0;
		s_a = 0;
		for (int i = 0; i < 4; i++) begin
			a = px[i][31:24];
			if (a >= thr_reg)
				n++;
			s_r += px[i][7:0] * a;
			s_g += px[i][15:8] * a;
			s_b += px[i][23:16] * a;
			s_a += a;
		end
		if (s_a != 0) begin
			r.out_red = 8'(s_r / s_a);
			r.out_green = 8'(s_g / s_a);
			r.out_blue = 8'(s_b / s_a);
		end else begin
			r.out_red = '0;
			r.out_green = '0;
			r.out_blue = '0;
		end
		if (n == 0) begin
			oa = s_a / 4;
		end else begin
			plain = 4 * s_a;
			boosted = 4 * n * boost_reg + (4 - n) * s_a;
			oa = (boosted > plain ? boosted : plain) / 16;
		end
		if (oa > 255)
			oa = 255;
		r.out_alpha = 8'(oa);
		return r;
	endfunction

	// Alpha biased toward zero, full and the threshold edges
	function automatic logic [31:0] rand_pixel();
		logic [7:0] a;
		case ($urandom_range(5, 0))
			0: a = 8'h00;
			1: a = 8'hFF;
			2: a = thr_reg - 8'd1;
			3: a = thr_reg;
			default: a = 8'($urandom);
		endcase
		return {a, 24'($urandom)};
	endfunction

	// APB write; upper data bits carry junk that the block must drop
	task automatic apb_write(input logic idx, input logic [7:0] val);
		logic [31:0] junk;
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ALPHA_THRESHOLD)
			thr_reg = val;
		else
			boost_reg = val;
		@(posedge clk);
	endtask

	// Offer one block; the expectation is queued at the accepting edge
	task automatic offer_block(input src_item_t blk, input logic typed, input res_item_t want);
		int gap;
		gap = $urandom_range(src_idle_max, 0);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= blk;
		do @(posedge clk); while (src_stall);
		pending_pixels.push_back(typed ? want : downsample_block(blk));
	endtask

	// Stop offering and wait until the pipeline is empty
	task automatic settle_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stall per item, plus the long hold-off on request
	initial begin : result_stall
		int hold;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end
			hold = $urandom_range(res_idle_max, 0);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result %h", res_item);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (res_item.out_red !== want.out_red) begin
					$error("out_red: expected %0d, got %0d", want.out_red, res_item.out_red);
					mismatch_count++;
				end
				if (res_item.out_green !== want.out_green) begin
					$error("out_green: expected %0d, got %0d", want.out_green,
						res_item.out_green);
					mismatch_count++;
				end
				if (res_item.out_blue !== want.out_blue) begin
					$error("out_blue: expected %0d, got %0d", want.out_blue, res_item.out_blue);
					mismatch_count++;
				end
				if (res_item.out_alpha !== want.out_alpha) begin
					$error("out_alpha: expected %0d, got %0d", want.out_alpha,
						res_item.out_alpha);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		src_item_t blk;
		logic [7:0] thr_val, boost_val;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset settings
		for (int i = 0; i < DIR_ROWS_N; i++) begin
			row = DIR_ROWS[i];
			offer_block(row.blk, row.typed, row.want);
		end

		// Random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle_idle();
			thr_val = PH_THR[p];
			boost_val = PH_BOOST[p];
			if (p == RANDOM_PHASE) begin
				thr_val = 8'($urandom);
				boost_val = 8'($urandom);
			end
			apb_write(REG_ALPHA_THRESHOLD, thr_val);
			apb_write(REG_BOOST_TARGET, boost_val);
			src_idle_max = PH_SRC_MAX[p];
			res_idle_max = PH_RES_MAX[p];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (PH_FILL[p] && k == 10)
					long_hold_req = 1'b1;
				if (PH_DRAIN[p] && k == 50)
					settle_idle();
				blk = {rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()};
				offer_block(blk, 1'b0, '0);
			end
		end

		settle_idle();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
hdl/acmd_pkg.sv
hdl/acmd_cfg.sv
hdl/acmd_front.sv
hdl/acmd_div_stage.sv
hdl/alpha_coverage_mip_downsample_top.sv
bench/alpha_coverage_mip_downsample_top_tb.sv
